// ===== rtl/core/amd_pkg.sv =====
`default_nettype none
package amd_pkg;

  localparam int NumOutputs = 16;
  localparam int NumAxes    = 6;
  localparam int WrenchLen  = 6;
  localparam logic signed [15:0] QOne = 16'sd4096;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_LIMIT = 2'd1,
    OP_MIX   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_acc;   // start a new row sum
    logic mac;       // accumulate one product
    logic store_raw; // round and store the finished row
    logic clr_ext;   // clear overflow/underflow
    logic scan;      // fold one output into overflow/underflow
    logic emit;      // present one result
  } ctl_t;

  // X quadcopter default coefficient for row r, column c
  function automatic logic signed [15:0] quad_coef(int r, int c);
    logic signed [15:0] v;
    v = 16'sd0;
    if (r < 4 && c >= 2 && c < 6) begin
      case (r)
        0: v = (c == 2 || c == 5) ? QOne : -QOne;
        1: v = QOne;
        2: v = (c == 2 || c == 3) ? QOne : -QOne;
        default: v = (c == 2 || c == 4) ? QOne : -QOne;
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/amd_ctrl.sv =====
`default_nettype none
module amd_ctrl #(
  parameter int NUM_OUTPUTS = amd_pkg::NumOutputs,
  parameter int NUM_AXES    = amd_pkg::NumAxes,
  localparam int RW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1,
  localparam int CW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mix_i,
  output amd_pkg::ctl_t      ctl_o,
  output logic [RW-1:0]      row_o,
  output logic [CW-1:0]      col_o,
  output logic               busy_o
);

  amd_pkg::state_e state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic row_last, col_last;

  assign row_last = (row_q == RW'(NUM_OUTPUTS - 1));
  assign col_last = (col_q == CW'(NUM_AXES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amd_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    ctl_o   = '0;
    busy_o  = (state_q != amd_pkg::ST_IDLE);
    case (state_q)
      amd_pkg::ST_IDLE: begin
        if (mix_i) begin
          state_d       = amd_pkg::ST_MAC;
          row_d         = '0;
          col_d         = '0;
          ctl_o.clr_acc = 1'b1;
          ctl_o.clr_ext = 1'b1;
        end
      end
      amd_pkg::ST_MAC: begin
        ctl_o.mac = 1'b1;
        if (col_last) begin
          ctl_o.store_raw = 1'b1;
          ctl_o.clr_acc   = 1'b1;
          col_d           = '0;
          if (row_last) begin
            row_d   = '0;
            state_d = amd_pkg::ST_SCAN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      amd_pkg::ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (row_last) begin
          row_d   = '0;
          state_d = amd_pkg::ST_EMIT;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      amd_pkg::ST_EMIT: begin
        ctl_o.emit = 1'b1;
        if (row_last) begin
          row_d   = '0;
          state_d = amd_pkg::ST_IDLE;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      default: state_d = amd_pkg::ST_IDLE;
    endcase
  end

  assign row_o = row_q;
  assign col_o = col_q;

endmodule
`default_nettype wire

// ===== rtl/core/amd_dp.sv =====
`default_nettype none
module amd_dp #(
  parameter int NUM_OUTPUTS = amd_pkg::NumOutputs,
  parameter int NUM_AXES    = amd_pkg::NumAxes,
  localparam int RW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1,
  localparam int CW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1,
  localparam int Depth = NUM_OUTPUTS * NUM_AXES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [3:0]         output_index_i,
  input  wire logic [2:0]         axis_index_i,
  input  wire logic signed [15:0] coef_value_i,
  input  wire logic signed [15:0] limit_low_i,
  input  wire logic signed [15:0] limit_high_i,
  input  wire logic signed [15:0] force_x_i,
  input  wire logic signed [15:0] force_y_i,
  input  wire logic signed [15:0] force_z_i,
  input  wire logic signed [15:0] torque_x_i,
  input  wire logic signed [15:0] torque_y_i,
  input  wire logic signed [15:0] torque_z_i,
  input  wire amd_pkg::ctl_t      ctl_i,
  input  wire logic [RW-1:0]      row_i,
  input  wire logic [CW-1:0]      col_i,
  output logic                    valid_o,
  output logic [3:0]              actuator_number_o,
  output logic signed [15:0]      actuator_value_o,
  output logic                    last_output_o
);

  localparam int AW = $clog2(Depth + 1);
  localparam int IW = (Depth > 1) ? $clog2(Depth) : 1;

  // coefficient table: no reset, registered read; entries never written since
  // reset read the quad layout instead
  logic signed [15:0] mix_q [Depth];
  logic [Depth-1:0]   set_q;
  logic signed [15:0] lo_q [NUM_OUTPUTS];
  logic signed [15:0] hi_q [NUM_OUTPUTS];
  logic signed [15:0] raw_q [NUM_OUTPUTS];
  logic signed [15:0] wrench_q [amd_pkg::WrenchLen];

  logic accept, wr_coef, wr_lim, row_ok;
  assign accept  = start_i && !busy_i;
  assign row_ok  = ({2'b0, output_index_i} < 6'(NUM_OUTPUTS));
  assign wr_coef = accept && (opcode_i == amd_pkg::OP_COEF) && row_ok
                   && ({1'b0, axis_index_i} < 4'(NUM_AXES));
  assign wr_lim  = accept && (opcode_i == amd_pkg::OP_LIMIT) && row_ok;

  logic [AW-1:0] waddr;
  assign waddr = AW'(output_index_i) * AW'(NUM_AXES) + AW'(axis_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q <= '0;
      for (int r = 0; r < NUM_OUTPUTS; r++) begin
        lo_q[r] <= '0;
        hi_q[r] <= (r < 4) ? amd_pkg::QOne : 16'sd0;
      end
    end else begin
      if (wr_coef) set_q[waddr[IW-1:0]] <= 1'b1;
      if (wr_lim) begin
        lo_q[RW'(output_index_i)] <= limit_low_i;
        hi_q[RW'(output_index_i)] <= limit_high_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_coef) mix_q[waddr[IW-1:0]] <= coef_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == amd_pkg::OP_MIX) begin
      wrench_q[0] <= force_x_i;
      wrench_q[1] <= force_y_i;
      wrench_q[2] <= force_z_i;
      wrench_q[3] <= torque_x_i;
      wrench_q[4] <= torque_y_i;
      wrench_q[5] <= torque_z_i;
    end
  end

  // multiply-accumulate: operands registered, one product per cycle
  logic [AW-1:0] raddr;
  logic signed [15:0] coef, wcol;
  logic signed [15:0] coef_rd_q, coef_dft_q, wcol_q;
  logic coef_set_q, mac_q, store_q;
  logic [RW-1:0] mac_row_q;
  logic signed [31:0] prod;
  logic signed [35:0] acc_q, sum;
  logic signed [35:0] rnd;
  logic signed [23:0] fl;
  logic signed [15:0] raw_sat;
  assign raddr = AW'(row_i) * AW'(NUM_AXES) + AW'(col_i);

  always_comb begin
    wcol = 16'sd0;
    for (int k = 0; k < amd_pkg::WrenchLen; k++) begin
      if (int'(col_i) == k) wcol = wrench_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mac) begin
      coef_rd_q  <= mix_q[raddr[IW-1:0]];
      coef_set_q <= set_q[raddr[IW-1:0]];
      coef_dft_q <= amd_pkg::quad_coef(int'(row_i), int'(col_i));
      wcol_q     <= wcol;
      mac_row_q  <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q   <= 1'b0;
      store_q <= 1'b0;
    end else begin
      mac_q   <= ctl_i.mac;
      store_q <= ctl_i.store_raw;
    end
  end

  assign coef  = coef_set_q ? coef_rd_q : coef_dft_q;
  assign prod  = coef * wcol_q;
  assign sum   = acc_q + 36'(prod);
  assign rnd   = sum + 36'sd2048;
  assign fl    = rnd[35:12];
  assign raw_sat = (fl > 24'sd32767) ? 16'sd32767 :
                   (fl < -24'sd32768) ? -16'sd32768 : fl[15:0];

  // the last row is stored into raw_q while the scan reads row 0
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_acc && !ctl_i.mac) acc_q <= '0;
    else if (mac_q) acc_q <= store_q ? '0 : sum;
    if (store_q) raw_q[mac_row_q] <= raw_sat;
  end

  // desaturation scan and final clamp
  logic signed [17:0] over_q, under_q, v, lo, hi, dv, du, sh;
  assign v  = 18'(raw_q[row_i]);
  assign lo = 18'(lo_q[row_i]);
  assign hi = 18'(hi_q[row_i]);
  assign dv = v - hi;
  assign du = lo - v;

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_ext) begin
      over_q  <= '0;
      under_q <= '0;
    end else if (ctl_i.scan && !lo[17]) begin
      if (v > hi) begin
        if (dv > over_q) over_q <= dv;
      end else if (v < lo) begin
        if (du > under_q) under_q <= du;
      end
    end
  end

  always_comb begin
    sh = v;
    if (!lo[17]) sh = v - over_q + under_q;
    if (sh > hi) sh = hi;
    if (sh < lo) sh = lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= ctl_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      actuator_number_o <= 4'(row_i);
      actuator_value_o  <= sh[15:0];
      last_output_o     <= (row_i == RW'(NUM_OUTPUTS - 1));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/actuator_mixer_desaturate.sv =====
// Mix item: accept, then the MAC pass over every row and axis on the one shared
// multiply-accumulate unit, then a scan pass and an emit pass over the outputs.
// The results come on consecutive cycles; a new item is accepted only once busy
// has dropped, so mix items never overlap.
// Writes do not raise busy. The receiver cannot stall; results strobed by valid_o.
// Reset (async, active low) loads the X quadcopter table and default limits.
`default_nettype none
module actuator_mixer_desaturate #(
  parameter int NUM_OUTPUTS = amd_pkg::NumOutputs,
  parameter int NUM_AXES    = amd_pkg::NumAxes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [3:0]         output_index_i,
  input  wire logic [2:0]         axis_index_i,
  input  wire logic signed [15:0] coef_value_i,
  input  wire logic signed [15:0] limit_low_i,
  input  wire logic signed [15:0] limit_high_i,
  input  wire logic signed [15:0] force_x_i,
  input  wire logic signed [15:0] force_y_i,
  input  wire logic signed [15:0] force_z_i,
  input  wire logic signed [15:0] torque_x_i,
  input  wire logic signed [15:0] torque_y_i,
  input  wire logic signed [15:0] torque_z_i,
  output logic                    valid_o,
  output logic [3:0]              actuator_number_o,
  output logic signed [15:0]      actuator_value_o,
  output logic                    last_output_o
);

  localparam int RW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int CW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  amd_pkg::ctl_t ctl;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic mix;

  assign mix = start && (opcode_i == amd_pkg::OP_MIX);

  amd_ctrl #(.NUM_OUTPUTS(NUM_OUTPUTS), .NUM_AXES(NUM_AXES)) u_ctrl (
    .clk_i, .rst_ni, .mix_i(mix), .ctl_o(ctl), .row_o(row), .col_o(col),
    .busy_o(busy)
  );

  amd_dp #(.NUM_OUTPUTS(NUM_OUTPUTS), .NUM_AXES(NUM_AXES)) u_dp (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .opcode_i,
    .output_index_i, .axis_index_i, .coef_value_i, .limit_low_i,
    .limit_high_i, .force_x_i, .force_y_i, .force_z_i, .torque_x_i,
    .torque_y_i, .torque_z_i, .ctl_i(ctl), .row_i(row), .col_i(col),
    .valid_o, .actuator_number_o, .actuator_value_o, .last_output_o
  );

endmodule
`default_nettype wire

// ===== rtl/core/amd_checker.sv =====
`default_nettype none
module amd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] opcode_i,
  input wire logic       valid_o,
  input wire logic [3:0] actuator_number_o,
  input wire logic       last_output_o
);

  a_mix_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == amd_pkg::OP_MIX |=> busy) else $error("mix not busy");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i != amd_pkg::OP_MIX |=> !busy) else $error("write busy");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_output_o |=> valid_o &&
    actuator_number_o == $past(actuator_number_o) + 4'd1)
    else $error("result order");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_output_o |-> !busy) else $error("busy after last");

endmodule

bind actuator_mixer_desaturate amd_checker u_amd_checker (
  .clk_i, .rst_ni, .start, .busy, .opcode_i, .valid_o, .actuator_number_o,
  .last_output_o
);
`default_nettype wire
